// ----- hdl/bba_pkg.sv -----
// Package: types, constants and helper functions of the bitmap block allocator.
package bba_pkg;

    localparam int ENTRIES   = 128;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int FI_W      = 7;
    localparam int BN_W      = 8;
    localparam int ST_W      = 2;
    localparam int FC_W      = 8;

    localparam int FIRST_RST = 16;
    localparam logic [CNT_W-1:0] FREE_RST =
        (FIRST_RST < ENTRIES) ? CNT_W'(ENTRIES - FIRST_RST) : '0;

    // recount sweep geometry
    localparam int CHUNK    = 8;
    localparam int NCHUNK   = ENTRIES / CHUNK;
    localparam int CHUNK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PCNT_W   = $clog2(CHUNK + 1);

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic            cmd;
        logic [BN_W-1:0] block_number;
    } t_req;

    typedef struct packed {
        logic [BN_W-1:0] granted_block;
        logic [ST_W-1:0] status;
        logic [FC_W-1:0] free_count;
    } t_rsp;

    // free count load from the recount sweep
    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] value;
    } t_cnt_load;

    // bit i set where index i may be allocated
    function automatic logic [ENTRIES-1:0] avail_mask(input logic [FI_W-1:0] first_index);
        logic [ENTRIES-1:0] m;
        m = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            m[i] = (i >= int'(first_index));
        end
        return m;
    endfunction

    function automatic logic [PCNT_W-1:0] popcount(input logic [CHUNK-1:0] v);
        logic [PCNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < CHUNK; i++) begin
            n = n + PCNT_W'(v[i]);
        end
        return n;
    endfunction

endpackage

// ----- hdl/bba_recount.sv -----
// Free-count recount: sweeps the used-map one chunk per cycle after a first_index write.
module bba_recount (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bba_pkg::FI_W-1:0]    i_first_index,
    input  logic [bba_pkg::ENTRIES-1:0] i_used_map,
    output logic                        o_busy,
    output bba_pkg::t_cnt_load          o_load
);
    import bba_pkg::*;

    logic               r_busy, n_busy;
    logic [CHUNK_W-1:0] r_chunk, n_chunk;
    logic [CNT_W-1:0]   r_acc, n_acc;
    logic [ENTRIES-1:0] free_vec;
    logic [CNT_W-1:0]   sum;
    logic               last;

    always_comb begin
        free_vec = ~i_used_map & avail_mask(i_first_index);
        sum      = r_acc + CNT_W'(popcount(free_vec[int'(r_chunk) * CHUNK +: CHUNK]));
        last     = (int'(r_chunk) == NCHUNK - 1);
        n_busy   = r_busy;
        n_chunk  = r_chunk;
        n_acc    = r_acc;
        if (i_start) begin
            n_busy  = 1'b1;
            n_chunk = '0;
            n_acc   = '0;
        end else if (r_busy) begin
            n_acc   = sum;
            n_chunk = r_chunk + CHUNK_W'(1);
            if (last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_chunk <= n_chunk;
        r_acc   <= n_acc;
    end

    assign o_busy       = r_busy;
    assign o_load.load  = r_busy && last;
    assign o_load.value = sum;

endmodule

// ----- hdl/bba_map.sv -----
// Used-map and free count with the first-fit search and release check.
module bba_map (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  bba_pkg::t_req               i_req,
    input  logic [bba_pkg::FI_W-1:0]    i_first_index,
    input  bba_pkg::t_cnt_load          i_load,
    output bba_pkg::t_rsp               o_rsp,
    output logic [bba_pkg::ENTRIES-1:0] o_used_map
);
    import bba_pkg::*;

    logic [ENTRIES-1:0] r_used_map, n_used_map;
    logic [CNT_W-1:0]   r_free_total, n_free_total;

    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] lowest;
    logic               found;
    logic [IDX_W-1:0]   found_idx;
    logic [BN_W-1:0]    rel_idx_w;
    logic [IDX_W-1:0]   rel_idx;
    logic               rel_bad;

    always_comb begin
        // first fit: isolate lowest free bit, then encode it
        free_vec  = ~r_used_map & avail_mask(i_first_index);
        lowest    = free_vec & (~free_vec + ENTRIES'(1));
        found     = |free_vec;
        found_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (lowest[i]) begin
                found_idx = found_idx | IDX_W'(i);
            end
        end

        rel_idx_w = i_req.block_number - BN_W'(1);
        rel_idx   = rel_idx_w[IDX_W-1:0];
        rel_bad   = (i_req.block_number == '0) ||
                    (int'(i_req.block_number) > ENTRIES) ||
                    (int'(rel_idx_w) < int'(i_first_index)) ||
                    !r_used_map[rel_idx];

        n_used_map          = r_used_map;
        n_free_total        = r_free_total;
        o_rsp.granted_block = '0;
        o_rsp.status        = ST_OK;

        case (i_req.cmd)
            CMD_ALLOC: begin
                if (found) begin
                    n_used_map[found_idx] = 1'b1;
                    n_free_total          = r_free_total - CNT_W'(1);
                    o_rsp.granted_block   = BN_W'(found_idx) + BN_W'(1);
                end else begin
                    o_rsp.status = ST_FULL;
                end
            end
            CMD_RELEASE: begin
                if (rel_bad) begin
                    o_rsp.status = ST_BAD;
                end else begin
                    n_used_map[rel_idx] = 1'b0;
                    n_free_total        = r_free_total + CNT_W'(1);
                end
            end
            default: begin
                o_rsp.status = ST_OK;
            end
        endcase
        o_rsp.free_count = FC_W'(n_free_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_map   <= '0;
            r_free_total <= FREE_RST;
        end else if (i_load.load) begin
            r_free_total <= i_load.value;
        end else if (i_fire) begin
            r_used_map   <= n_used_map;
            r_free_total <= n_free_total;
        end
    end

    assign o_used_map = r_used_map;

endmodule

// ----- hdl/bitmap_block_allocator.sv -----
// Top level: first-fit bitmap block allocator with input and result registers.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | into      | i_in_valid/o_in_stall  | t_req: cmd, block_number
//  out     | out of    | o_out_valid/i_out_stall| t_rsp: granted_block, status,
//          |           |                    |        free_count
//  cfg     | into      | i_cfg_valid/o_cfg_ready| first_index (7 bits)
//
// One item per cycle while neither a stall nor a recount holds the flow: an
// accepted item sits in the input register, the 128-bit first-free search and
// map update run as it leaves that register, and the result lands in the output register.
// Reset (synchronous, active low) clears the used-map, sets first_index to 16
// and the free count to 112. A first_index write starts a recount of the map
// at 8 bits a cycle, during which o_cfg_ready is low and input is
// stalled. A stalled output holds its result while one more item waits in
// the input register; only then is input stalled.
module bitmap_block_allocator (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  bba_pkg::t_req            i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output bba_pkg::t_rsp            o_out_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [bba_pkg::FI_W-1:0] i_cfg_data
);
    import bba_pkg::*;

    logic            r_in_valid, n_in_valid;
    t_req            r_in, n_in;
    logic            r_out_valid, n_out_valid;
    t_rsp            r_out, n_out;
    logic [FI_W-1:0] r_first_index, n_first_index;

    logic               busy;
    logic               advance;
    logic               cfg_fire;
    t_rsp               rsp;
    t_cnt_load          cnt_load;
    logic [ENTRIES-1:0] used_map;

    bba_map u_map (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (advance),
        .i_req         (r_in),
        .i_first_index (r_first_index),
        .i_load        (cnt_load),
        .o_rsp         (rsp),
        .o_used_map    (used_map)
    );

    bba_recount u_recount (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (cfg_fire),
        .i_first_index (r_first_index),
        .i_used_map    (used_map),
        .o_busy        (busy),
        .o_load        (cnt_load)
    );

    // the queued item moves on whenever no recount runs and the result slot is free or draining
    assign advance     = r_in_valid && !busy && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = busy || (r_in_valid && !advance);
    assign o_cfg_ready = !busy;
    assign cfg_fire    = i_cfg_valid && !busy;

    always_comb begin
        n_in_valid    = r_in_valid;
        n_in          = r_in;
        n_out_valid   = r_out_valid;
        n_out         = r_out;
        n_first_index = r_first_index;

        if (!o_in_stall) begin
            n_in_valid = i_in_valid;
            n_in       = i_in_data;
        end

        if (advance) begin
            n_out_valid = 1'b1;
            n_out       = rsp;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (cfg_fire) begin
            n_first_index = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_first_index <= FI_W'(FIRST_RST);
        end else begin
            r_in_valid    <= n_in_valid;
            r_out_valid   <= n_out_valid;
            r_first_index <= n_first_index;
        end
        r_in  <= n_in;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- tb/bitmap_block_allocator_test.sv -----
// Testbench for the bitmap block allocator: directed table plus random phases, self-checking.
`timescale 1ns / 1ps

module bitmap_block_allocator_test;
    import bba_pkg::*;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 205;
    localparam int IDLE_PCT    = 34;
    localparam int JAM_CYCLES  = 80;

    typedef enum bit {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind       kind;
        t_req            req;
        logic [FI_W-1:0] cfg;
        bit              fixed;
        t_rsp            want;
    } t_plan_row;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_in_valid  = 1'b0;
    logic            o_in_stall;
    t_req            i_in_data   = '0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    t_rsp            o_out_data;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [FI_W-1:0] i_cfg_data  = '0;

    // allocator shadow: used-map, first allocatable index, free count
    logic [ENTRIES-1:0] taken_map = '0;
    logic [FI_W-1:0]    first_idx = '0;
    int unsigned        free_left = 0;

    t_rsp        pending_rsp[$];
    t_plan_row   plan[$];
    int unsigned errors  = 0;
    int unsigned n_sent  = 0;
    int unsigned n_done  = 0;

    // sender-side knobs read by the receiver
    bit          calm      = 1'b0;
    bit          jam_ask   = 1'b0;
    bit          jam_done  = 1'b0;
    int unsigned jam_left  = 0;

    // typed-in expectation riding along with the current item
    bit   fixed_on  = 1'b0;
    t_rsp fixed_rsp = '0;

    bitmap_block_allocator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------- prediction ----------------

    function automatic int unsigned count_open();
        int unsigned n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (i >= int'(first_idx) && !taken_map[i]) n++;
        end
        return n;
    endfunction

    // register write keeps the map and recounts the free blocks
    function automatic void load_first(input logic [FI_W-1:0] v);
        first_idx = v;
        free_left = count_open();
    endfunction

    function automatic t_rsp serve(input t_req r);
        t_rsp res;
        int   pick;
        int   num;
        res  = '0;
        res.status = ST_OK;
        pick = -1;
        if (r.cmd == CMD_ALLOC) begin
            // scan downward so the last hit is the lowest free index
            for (int i = ENTRIES - 1; i >= int'(first_idx); i--) begin
                if (!taken_map[i]) pick = i;
            end
            if (pick >= 0) begin
                taken_map[pick] = 1'b1;
                if (free_left > 0) free_left--;
                res.granted_block = BN_W'(pick + 1);
            end else begin
                res.status = ST_FULL;
            end
        end else begin
            num = int'(r.block_number);
            if (num == 0 || num > ENTRIES) begin
                res.status = ST_BAD;
            end else if (num - 1 < int'(first_idx) || !taken_map[num - 1]) begin
                res.status = ST_BAD;   // reserved or already free
            end else begin
                taken_map[num - 1] = 1'b0;
                free_left++;
            end
        end
        res.free_count = FC_W'(free_left);
        return res;
    endfunction

    // ---------------- checking ----------------

    task automatic report_miss(input string what);
        $display("[%0t] MISMATCH %s", $time, what);
        errors++;
    endtask

    task automatic check_rsp(input t_rsp got, input t_rsp want);
        if (got.granted_block !== want.granted_block)
            report_miss($sformatf("granted_block got %0d want %0d",
                                  got.granted_block, want.granted_block));
        if (got.status !== want.status)
            report_miss($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.free_count !== want.free_count)
            report_miss($sformatf("free_count got %0d want %0d",
                                  got.free_count, want.free_count));
    endtask

    // all handshakes sampled at the edge, before any update lands
    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            taken_map = '0;
            load_first(FI_W'(FIRST_RST));
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_done <= n_done + 1;
                if (pending_rsp.size() == 0) begin
                    report_miss("result with no request outstanding");
                end else begin
                    want = pending_rsp.pop_front();
                    check_rsp(o_out_data, want);
                end
            end
            if (i_cfg_valid && o_cfg_ready) load_first(i_cfg_data);
            if (i_in_valid && !o_in_stall) begin
                want = serve(i_in_data);
                pending_rsp.push_back(fixed_on ? fixed_rsp : want);
            end
        end
    end

    // ---------------- receiver ----------------

    // one long hold-off on request, random stalls otherwise
    always @(posedge i_clk) begin
        if (jam_left != 0) begin
            jam_left    <= jam_left - 1;
            i_out_stall <= 1'b1;
        end else if (jam_ask && !jam_done) begin
            jam_done    <= 1'b1;
            jam_left    <= JAM_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // ---------------- sender ----------------

    task automatic offer(input t_req r, input bit fixed, input t_rsp want);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        fixed_on   <= fixed;
        fixed_rsp  <= want;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_sent++;
    endtask

    // hold input low until every outstanding item has its result
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (n_done < n_sent);
    endtask

    task automatic write_first(input logic [FI_W-1:0] v);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void put_req(input logic cmd, input logic [BN_W-1:0] num,
                                    input bit fixed, input logic [BN_W-1:0] g,
                                    input logic [ST_W-1:0] s, input logic [FC_W-1:0] f);
        t_plan_row row;
        row.kind                = ROW_REQ;
        row.req.cmd             = cmd;
        row.req.block_number    = num;
        row.cfg                 = '0;
        row.fixed               = fixed;
        row.want.granted_block  = g;
        row.want.status         = s;
        row.want.free_count     = f;
        plan.push_back(row);
    endfunction

    function automatic void put_cfg(input logic [FI_W-1:0] v);
        t_plan_row row;
        row      = '{kind: ROW_CFG, req: '0, cfg: v, fixed: 1'b0, want: '0};
        plan.push_back(row);
    endfunction

    // a block number that is currently in use and allocatable, else a random one
    function automatic logic [BN_W-1:0] pick_taken();
        int start;
        int i;
        start = $urandom_range(0, ENTRIES - 1);
        for (int k = 0; k < ENTRIES; k++) begin
            i = (start + k) % ENTRIES;
            if (taken_map[i] && i >= int'(first_idx)) return BN_W'(i + 1);
        end
        return BN_W'($urandom_range(1, ENTRIES));
    endfunction

    initial begin : stim
        t_req            req;
        int              bias;
        int              roll;
        logic [FI_W-1:0] fi;

        // after reset: first index 16, 112 free
        put_req(CMD_ALLOC,   8'd0,   1, 8'd17, ST_OK,   8'd111);
        put_req(CMD_ALLOC,   8'hFF,  1, 8'd18, ST_OK,   8'd110);  // number ignored
        put_req(CMD_RELEASE, 8'd17,  1, 8'd0,  ST_OK,   8'd111);
        put_req(CMD_RELEASE, 8'd17,  1, 8'd0,  ST_BAD,  8'd111);  // already free
        put_req(CMD_RELEASE, 8'd0,   1, 8'd0,  ST_BAD,  8'd111);
        put_req(CMD_RELEASE, 8'd129, 1, 8'd0,  ST_BAD,  8'd111);  // past the map
        put_req(CMD_RELEASE, 8'hFF,  1, 8'd0,  ST_BAD,  8'd111);
        put_req(CMD_RELEASE, 8'd16,  1, 8'd0,  ST_BAD,  8'd111);  // reserved
        put_req(CMD_RELEASE, 8'd1,   1, 8'd0,  ST_BAD,  8'd111);
        put_req(CMD_ALLOC,   8'd0,   1, 8'd17, ST_OK,   8'd110);
        put_req(CMD_RELEASE, 8'd128, 1, 8'd0,  ST_BAD,  8'd110);
        // only the top block allocatable
        put_cfg(7'd127);
        put_req(CMD_ALLOC,   8'd0,   1, 8'd128, ST_OK,  8'd0);
        put_req(CMD_ALLOC,   8'd0,   1, 8'd0,   ST_FULL, 8'd0);
        put_req(CMD_RELEASE, 8'd128, 1, 8'd0,   ST_OK,  8'd1);
        put_req(CMD_RELEASE, 8'd18,  1, 8'd0,   ST_BAD, 8'd1);    // used but now reserved
        // nothing reserved: blocks 17 and 18 still held
        put_cfg(7'd0);
        put_req(CMD_ALLOC,   8'd0,   1, 8'd1,   ST_OK,  8'd125);
        put_req(CMD_ALLOC,   8'h80,  1, 8'd2,   ST_OK,  8'd124);
        put_req(CMD_RELEASE, 8'd18,  1, 8'd0,   ST_OK,  8'd125);
        put_req(CMD_RELEASE, 8'd1,   1, 8'd0,   ST_OK,  8'd126);
        put_req(CMD_RELEASE, 8'd2,   0, '0, ST_OK, '0);
        put_req(CMD_ALLOC,   8'h7F,  0, '0, ST_OK, '0);
        put_req(CMD_ALLOC,   8'd0,   0, '0, ST_OK, '0);
        put_cfg(7'd100);
        put_req(CMD_ALLOC,   8'd0,   0, '0, ST_OK, '0);
        put_req(CMD_RELEASE, 8'd128, 0, '0, ST_OK, '0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) write_first(plan[k].cfg);
            else offer(plan[k].req, plan[k].fixed, plan[k].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                1:       fi = 7'd0;
                2:       fi = 7'd127;
                3:       fi = 7'd64;
                5:       fi = 7'd1;
                6:       fi = 7'd120;
                default: fi = FI_W'($urandom_range(0, 127));
            endcase
            if (p != 0) write_first(fi);
            calm = (p == 3);
            if (p == 1) jam_ask = 1'b1;   // fill the block while the output is held
            // odd phases lean on allocation to reach a full map
            bias = (p % 2 == 1) ? 85 : $urandom_range(30, 60);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 5 && n == PHASE_ITEMS / 2) drain();
                roll = $urandom_range(0, 99);
                req.block_number = BN_W'($urandom_range(0, 255));
                if (roll < bias) begin
                    req.cmd = CMD_ALLOC;
                end else begin
                    req.cmd = CMD_RELEASE;
                    // mostly legal releases, the rest are noise
                    if ($urandom_range(0, 3) != 0) req.block_number = pick_taken();
                end
                offer(req, 1'b0, '0);
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (pending_rsp.size() != 0)
            report_miss($sformatf("%0d results never arrived", pending_rsp.size()));
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
